>>> sv/tca_pkg.sv
// Shared types, constants and the saturation helper function of the tick clock alignment block.
`timescale 1ns / 1ps
`default_nettype none

package tca_pkg;

    localparam int DEPTH_DEFAULT = 16;

    localparam int TICK_W     = 32;
    localparam int HOST_W     = 48;
    localparam int FLAGS_W    = 16;
    localparam int CONV_W     = 43;
    localparam int BASE_W     = 49;
    localparam int SUM_W      = 51;
    localparam int PHASE_W    = 2;
    localparam int CHK_TOL_W  = 20;
    localparam int ALR_TOL_W  = 24;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_CHECK_TOL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ALERT_TOL = 1'b1;

    localparam logic [CHK_TOL_W-1:0] CHECK_TOL_RESET = 20'd5000;
    localparam logic [ALR_TOL_W-1:0] ALERT_TOL_RESET = 24'd20000;

    localparam logic [PHASE_W-1:0] PHASE_UNALIGNED = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_ALIGNING  = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_ALIGNED   = 2'd2;

    localparam logic [FLAGS_W-1:0] FULL_RATE_MASK = 16'h003F;

    // tick * 5000 / 3 = tick * 1666 + floor(tick * 2 / 3)
    localparam logic [CONV_W-1:0] CONV_INT_K = 43'd1666;

    typedef struct packed {
        logic [HOST_W-1:0] host;
        logic [CONV_W-1:0] conv;
    } sample_t;

    function automatic logic signed [BASE_W-1:0] sat_base(input logic signed [SUM_W-1:0] v);
        logic signed [BASE_W-1:0] r;
        if ((&v[SUM_W-1:BASE_W-1]) || !(|v[SUM_W-1:BASE_W-1])) begin
            r = $signed(v[BASE_W-1:0]);
        end
        else if (v[SUM_W-1]) begin
            r = $signed({1'b1, {(BASE_W-1){1'b0}}});
        end
        else begin
            r = $signed({1'b0, {(BASE_W-1){1'b1}}});
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> sv/tca_conv.sv
// Multi-cycle tick to microsecond converter, four quotient bits of the divide by three per cycle.
`timescale 1ns / 1ps
`default_nettype none

module tca_conv
    import tca_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [TICK_W-1:0] tick,
    output logic                   done,
    output logic [CONV_W-1:0]      result
);

    localparam int DIV_W  = 36;
    localparam int DIGITS = DIV_W / 4;
    localparam int CNT_W  = $clog2(DIGITS + 1);

    logic              busy_reg;
    logic              busy_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              done_reg;
    logic              done_next;
    logic [1:0]        rem_reg;
    logic [1:0]        rem_next;
    logic [DIV_W-1:0]  div_reg;
    logic [DIV_W-1:0]  div_next;
    logic [CONV_W-1:0] prod_reg;
    logic [CONV_W-1:0] prod_next;
    logic [CONV_W-1:0] result_reg;
    logic [CONV_W-1:0] result_next;

    logic [2:0]        trial;
    logic [1:0]        rem_step;
    logic [3:0]        q_digit;

    always_comb
    begin
        rem_step = rem_reg;
        q_digit  = 4'b0;
        trial    = 3'b0;
        for (int i = 3; i >= 0; i--)
        begin
            trial = {rem_step, div_reg[DIV_W-4+i]};
            if (trial >= 3'd3)
            begin
                rem_step   = 2'(trial - 3'd3);
                q_digit[i] = 1'b1;
            end
            else
            begin
                rem_step = trial[1:0];
            end
        end
    end

    always_comb
    begin
        busy_next   = busy_reg;
        cnt_next    = cnt_reg;
        done_next   = 1'b0;
        rem_next    = rem_reg;
        div_next    = div_reg;
        prod_next   = prod_reg;
        result_next = result_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIGITS);
            rem_next  = 2'b0;
            div_next  = {{(DIV_W-TICK_W-1){1'b0}}, tick, 1'b0};
            prod_next = CONV_W'(tick) * CONV_INT_K;
        end
        else if (busy_reg)
        begin
            if (cnt_reg != '0)
            begin
                cnt_next = cnt_reg - 1'b1;
                rem_next = rem_step;
                div_next = {div_reg[DIV_W-5:0], q_digit};
            end
            else
            begin
                busy_next   = 1'b0;
                done_next   = 1'b1;
                result_next = prod_reg + CONV_W'(div_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg    <= rem_next;
        div_reg    <= div_next;
        prod_reg   <= prod_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

>>> sv/tca_ring_mem.sv
// Sample ring memory with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module tca_ring_mem
    import tca_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire sample_t                  wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output sample_t                       rdata
);

    sample_t mem_reg [DEPTH];
    sample_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> sv/tick_clock_alignment.sv
// Top level of the tick clock alignment block: control sequencer, state registers and outputs.
//
//   Channel  Signals                           Direction  Transaction
//   in       in_valid/in_ready + 3 fields      sink       one device message
//   out      out_valid/out_ready + 5 fields    source     one result per message
//   cfg      cfg_valid/cfg_ready, index, data  sink       one register write
//
// An unaligned or aligning message passes from acceptance through the tick converter to the
// output state; an aligned message adds the stamp states (add, error). When the ring
// is full in the aligning phase, a full-rate message scans the stored samples, each through
// a memory read, an add and a compare, until one fails the check or all pass.
// One message is processed at a time; the output register lets the next message enter
// while a result waits, and a stalled receiver holds the sequencer in its output state.
// Reset clears phase, base, ring pointers and out_valid and loads the default tolerances.
`timescale 1ns / 1ps
`default_nettype none

module tick_clock_alignment
    import tca_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [TICK_W-1:0]       tick_count,
    input  wire logic [HOST_W-1:0]       host_time_us,
    input  wire logic [FLAGS_W-1:0]      flag_word,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [PHASE_W-1:0]           phase,
    output logic signed [BASE_W-1:0]     base_time_us,
    output logic signed [BASE_W-1:0]     stamped_time_us,
    output logic signed [BASE_W-1:0]     time_error_us,
    output logic                         alert,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   cfg_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [9:0] {
        S_IDLE      = 10'b0000000001,
        S_CONV      = 10'b0000000010,
        S_SCAN_RD   = 10'b0000000100,
        S_SCAN_ADD  = 10'b0000001000,
        S_SCAN_CMP  = 10'b0000010000,
        S_BASE_RD   = 10'b0000100000,
        S_BASE_SUB  = 10'b0001000000,
        S_STAMP_ADD = 10'b0010000000,
        S_STAMP_ERR = 10'b0100000000,
        S_OUT       = 10'b1000000000
    } state_t;

    state_t                   state_reg;
    state_t                   state_next;
    logic [PHASE_W-1:0]       phase_reg;
    logic [PHASE_W-1:0]       phase_next;
    logic signed [BASE_W-1:0] base_reg;
    logic signed [BASE_W-1:0] base_next;
    logic [AW-1:0]            head_reg;
    logic [AW-1:0]            head_next;
    logic [CW-1:0]            count_reg;
    logic [CW-1:0]            count_next;
    logic [AW-1:0]            ptr_reg;
    logic [AW-1:0]            ptr_next;
    logic [AW-1:0]            k_reg;
    logic [AW-1:0]            k_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic [CHK_TOL_W-1:0]     chk_tol_reg;
    logic [CHK_TOL_W-1:0]     chk_tol_next;
    logic [ALR_TOL_W-1:0]     alr_tol_reg;
    logic [ALR_TOL_W-1:0]     alr_tol_next;

    logic [HOST_W-1:0]        host_reg;
    logic [HOST_W-1:0]        host_next;
    logic                     full_reg;
    logic                     full_next;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [SUM_W-1:0]  sum_next;
    logic signed [BASE_W-1:0] stamped_reg;
    logic signed [BASE_W-1:0] stamped_next;
    logic signed [BASE_W-1:0] err_reg;
    logic signed [BASE_W-1:0] err_next;
    logic                     alert_reg;
    logic                     alert_next;

    logic [PHASE_W-1:0]       phase_o_reg;
    logic [PHASE_W-1:0]       phase_o_next;
    logic signed [BASE_W-1:0] base_o_reg;
    logic signed [BASE_W-1:0] base_o_next;
    logic signed [BASE_W-1:0] stamped_o_reg;
    logic signed [BASE_W-1:0] stamped_o_next;
    logic signed [BASE_W-1:0] err_o_reg;
    logic signed [BASE_W-1:0] err_o_next;
    logic                     alert_o_reg;
    logic                     alert_o_next;

    logic                     in_fire;
    logic                     conv_done;
    logic [CONV_W-1:0]        conv_result;
    logic                     mem_we;
    logic [AW-1:0]            mem_waddr;
    sample_t                  mem_wdata;
    logic                     mem_re;
    logic [AW-1:0]            mem_raddr;
    sample_t                  rd_sample;

    logic signed [SUM_W-1:0]  host_ext;
    logic signed [SUM_W-1:0]  base_ext;
    logic signed [SUM_W-1:0]  cres_ext;
    logic signed [SUM_W-1:0]  rconv_ext;
    logic signed [SUM_W-1:0]  rhost_ext;
    logic signed [SUM_W-1:0]  chk_ext;
    logic signed [SUM_W-1:0]  alr_ext;
    logic signed [SUM_W-1:0]  diff_new;
    logic signed [SUM_W-1:0]  diff_rd;
    logic signed [SUM_W-1:0]  dt;
    logic signed [SUM_W-1:0]  err_full;
    logic                     sample_fail;
    logic [AW:0]              slot_sum;
    logic [AW-1:0]            fill_slot;
    logic [AW-1:0]            ptr_inc;
    logic [AW-1:0]            head_after_fail;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    tca_conv u_conv (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (in_fire),
        .tick   (tick_count),
        .done   (conv_done),
        .result (conv_result)
    );

    tca_ring_mem #(
        .DEPTH (DEPTH)
    ) u_ring_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (rd_sample)
    );

    assign host_ext  = $signed({{(SUM_W-HOST_W){1'b0}}, host_reg});
    assign base_ext  = $signed({{(SUM_W-BASE_W){base_reg[BASE_W-1]}}, base_reg});
    assign cres_ext  = $signed({{(SUM_W-CONV_W){1'b0}}, conv_result});
    assign rconv_ext = $signed({{(SUM_W-CONV_W){1'b0}}, rd_sample.conv});
    assign rhost_ext = $signed({{(SUM_W-HOST_W){1'b0}}, rd_sample.host});
    assign chk_ext   = $signed({{(SUM_W-CHK_TOL_W){1'b0}}, chk_tol_reg});
    assign alr_ext   = $signed({{(SUM_W-ALR_TOL_W){1'b0}}, alr_tol_reg});

    assign diff_new    = host_ext - cres_ext;
    assign diff_rd     = host_ext - rconv_ext;
    assign dt          = rhost_ext - sum_reg;
    assign err_full    = host_ext - sum_reg;
    assign sample_fail = (dt > chk_ext) || (dt < -chk_ext);

    assign slot_sum  = (AW+1)'(head_reg) + (AW+1)'(count_reg);
    assign fill_slot = (slot_sum >= (AW+1)'(DEPTH)) ? AW'(slot_sum - (AW+1)'(DEPTH))
                                                    : slot_sum[AW-1:0];
    assign ptr_inc         = (ptr_reg == AW'(DEPTH - 1)) ? '0 : ptr_reg + 1'b1;
    assign head_after_fail = ptr_inc;

    assign mem_wdata = '{host: host_reg, conv: conv_result};
    assign mem_waddr = (state_reg == S_CONV) ? fill_slot : head_reg;
    assign mem_re    = (state_reg == S_SCAN_RD) || (state_reg == S_BASE_RD);
    assign mem_raddr = (state_reg == S_SCAN_RD) ? ptr_reg : head_reg;

    always_comb
    begin
        mem_we = 1'b0;
        if ((state_reg == S_CONV) && conv_done && (phase_reg == PHASE_ALIGNING) && full_reg
            && (count_reg != CW'(DEPTH)))
        begin
            mem_we = 1'b1;
        end
        else if ((state_reg == S_SCAN_CMP) && sample_fail)
        begin
            mem_we = 1'b1;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        base_next      = base_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        k_next         = k_reg;
        out_valid_next = out_valid_reg && !out_ready;
        chk_tol_next   = chk_tol_reg;
        alr_tol_next   = alr_tol_reg;
        host_next      = host_reg;
        full_next      = full_reg;
        sum_next       = sum_reg;
        stamped_next   = stamped_reg;
        err_next       = err_reg;
        alert_next     = alert_reg;
        phase_o_next   = phase_o_reg;
        base_o_next    = base_o_reg;
        stamped_o_next = stamped_o_reg;
        err_o_next     = err_o_reg;
        alert_o_next   = alert_o_reg;

        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_CHECK_TOL: chk_tol_next = cfg_data[CHK_TOL_W-1:0];
                REG_ALERT_TOL: alr_tol_next = cfg_data[ALR_TOL_W-1:0];
                default:       chk_tol_next = chk_tol_reg;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    host_next    = host_time_us;
                    full_next    = (flag_word & FULL_RATE_MASK) == FULL_RATE_MASK;
                    stamped_next = '0;
                    err_next     = '0;
                    alert_next   = 1'b0;
                    state_next   = S_CONV;
                end
            end
            S_CONV:
            begin
                if (conv_done)
                begin
                    state_next = S_OUT;
                    if (phase_reg == PHASE_ALIGNED)
                    begin
                        state_next = S_STAMP_ADD;
                    end
                    else if (full_reg && (phase_reg == PHASE_UNALIGNED))
                    begin
                        base_next  = $signed(diff_new[BASE_W-1:0]);
                        phase_next = PHASE_ALIGNING;
                    end
                    else if (full_reg)
                    begin
                        if (count_reg != CW'(DEPTH))
                        begin
                            count_next = count_reg + 1'b1;
                        end
                        else
                        begin
                            ptr_next   = head_reg;
                            k_next     = '0;
                            state_next = S_SCAN_RD;
                        end
                    end
                end
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_ADD;
            end
            S_SCAN_ADD:
            begin
                sum_next   = base_ext + rconv_ext;
                state_next = S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                if (sample_fail)
                begin
                    head_next  = head_after_fail;
                    count_next = CW'(DEPTH) - CW'(k_reg);
                    if (k_reg == AW'(DEPTH - 1))
                    begin
                        base_next  = $signed(diff_new[BASE_W-1:0]);
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_BASE_RD;
                    end
                end
                else if (k_reg == AW'(DEPTH - 1))
                begin
                    phase_next = PHASE_ALIGNED;
                    state_next = S_OUT;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    ptr_next   = ptr_inc;
                    state_next = S_SCAN_RD;
                end
            end
            S_BASE_RD:
            begin
                state_next = S_BASE_SUB;
            end
            S_BASE_SUB:
            begin
                base_next  = $signed(diff_rd[BASE_W-1:0]);
                state_next = S_OUT;
            end
            S_STAMP_ADD:
            begin
                sum_next   = base_ext + cres_ext;
                state_next = S_STAMP_ERR;
            end
            S_STAMP_ERR:
            begin
                stamped_next = sat_base(sum_reg);
                err_next     = sat_base(err_full);
                alert_next   = (err_full > alr_ext) || (err_full < -alr_ext);
                state_next   = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    phase_o_next   = phase_reg;
                    base_o_next    = base_reg;
                    stamped_o_next = stamped_reg;
                    err_o_next     = err_reg;
                    alert_o_next   = alert_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PHASE_UNALIGNED;
            base_reg      <= '0;
            head_reg      <= '0;
            count_reg     <= '0;
            ptr_reg       <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
            chk_tol_reg   <= CHECK_TOL_RESET;
            alr_tol_reg   <= ALERT_TOL_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            base_reg      <= base_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            ptr_reg       <= ptr_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
            chk_tol_reg   <= chk_tol_next;
            alr_tol_reg   <= alr_tol_next;
        end
    end

    always_ff @(posedge clk)
    begin
        host_reg      <= host_next;
        full_reg      <= full_next;
        sum_reg       <= sum_next;
        stamped_reg   <= stamped_next;
        err_reg       <= err_next;
        alert_reg     <= alert_next;
        phase_o_reg   <= phase_o_next;
        base_o_reg    <= base_o_next;
        stamped_o_reg <= stamped_o_next;
        err_o_reg     <= err_o_next;
        alert_o_reg   <= alert_o_next;
    end

    assign out_valid       = out_valid_reg;
    assign phase           = phase_o_reg;
    assign base_time_us    = base_o_reg;
    assign stamped_time_us = stamped_o_reg;
    assign time_error_us   = err_o_reg;
    assign alert           = alert_o_reg;

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("Ring fill count exceeds the ring depth.");

    a_aligned_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PHASE_ALIGNED |=> phase_reg == PHASE_ALIGNED)
        else $error("Phase left the aligned state.");

    a_conv_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        conv_done |-> state_reg == S_CONV)
        else $error("Converter finished while the sequencer was not waiting for it.");

    a_no_stamp_unaligned: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (phase_o_reg != PHASE_ALIGNED)) |->
            (!alert_o_reg && (stamped_o_reg == '0) && (err_o_reg == '0)))
        else $error("Stamp fields set on a transaction that is not aligned.");

endmodule

`default_nettype wire
